// ----- rtl/chs_pkg.sv -----
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types, constants and arithmetic helpers of the cosine hemisphere
// sampler.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int VECTOR_FRAC_BITS = 14;
  localparam int SAMPLE_BITS      = 16;
  localparam int CORDIC_STEPS     = 16;
  localparam int WORK_BITS        = 30;
  localparam int ONE              = 1 << VECTOR_FRAC_BITS;
  localparam int GAIN_Q30         = 652032874;
  localparam int INV_PI_Q32       = 1367130551;
  localparam int DENS_SHIFT       = VECTOR_FRAC_BITS + 16;
  localparam int DENS_MAX         = 32'h7FFF;

  // CORDIC datapath and per-stage square root lanes
  localparam int CW           = WORK_BITS + 3;
  localparam int SQ_STEPS     = WORK_BITS + 1;
  localparam int SQ_PER_STAGE = (SQ_STEPS + CORDIC_STEPS - 1) / CORDIC_STEPS;
  localparam int SQ_IN_W      = SAMPLE_BITS + 1;
  localparam int SQ_SHIFT     = 2 * WORK_BITS - SAMPLE_BITS;
  // radicand padded with leading zero digits so every stage slot has one
  localparam int SQ_N_W       = 2 * SQ_PER_STAGE * CORDIC_STEPS;
  localparam int REM_W        = SQ_STEPS + 3;

  // configuration register indexes
  localparam logic [1:0] REG_NORMAL_X  = 2'd0;
  localparam logic [1:0] REG_NORMAL_Y  = 2'd1;
  localparam logic [1:0] REG_NORMAL_Z  = 2'd2;
  localparam logic [1:0] REG_POLE_THR  = 2'd3;

  typedef struct packed {
    logic [15:0] rand_azimuth;
    logic [15:0] rand_elevation;
  } in_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [14:0]        density;
  } out_t;

  typedef struct packed {
    logic               busy;
    logic signed [15:0] zx;
    logic signed [15:0] zy;
    logic signed [15:0] zz;
    logic signed [15:0] xx;
    logic signed [15:0] xy;
    logic signed [15:0] yx;
    logic signed [15:0] yy;
    logic signed [15:0] yz;
  } frame_t;

  typedef struct packed {
    logic                valid;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [1:0]          quad;
    logic [SQ_STEPS-1:0] ct_root;
    logic [SQ_STEPS-1:0] st_root;
  } angle_t;

  // rounded right shift, ties away from zero
  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v,
                                                  input int unsigned s);
    logic [47:0] mag;
    logic [47:0] r;
    mag = v[47] ? 48'(-v) : 48'(v);
    r = (mag + (48'(1) << (s - 1))) >> s;
    return v[47] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [15:0] clamp1(input logic signed [47:0] v);
    if (v > 48'(ONE)) return 16'(ONE);
    if (v < -48'(ONE)) return -16'(ONE);
    return 16'(v);
  endfunction

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000028;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000002;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/chs_frame.sv -----
// ----------------------------------------------------------------------------
// chs_frame
// Configuration registers and sequential builder of the tangent frame.
// ----------------------------------------------------------------------------
module chs_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  output chs_pkg::frame_t       frame_o
);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_LOAD  = 5'b00010,
    F_SQRT  = 5'b00100,
    F_DIV   = 5'b01000,
    F_CROSS = 5'b10000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] nx_q, ny_q, nz_q;
  logic [14:0] thr_q;
  logic [14:0] root_q, root_d;
  logic [28:0] n_q, n_d;
  logic [28:0] na_q, na_d, nb_q, nb_d;
  logic [15:0] rema_q, rema_d, remb_q, remb_d;
  logic [28:0] qa_q, qa_d, qb_q, qb_d;
  logic signed [15:0] xx_q, xx_d, xy_q, xy_d, yx_q, yx_d, yy_q, yy_d, yz_q, yz_d;

  logic signed [15:0] zx, zy, zz;
  logic signed [31:0] zsq, p_yx, p_yy, p_zxy, p_zyx;
  logic [15:0] abs_x, abs_y, mag_a, mag_b;
  logic [14:0] trial;
  logic [29:0] sq;
  logic [15:0] ra, rb;
  logic        pole;

  assign zx = chs_pkg::clamp1(48'($signed(nx_q)));
  assign zy = chs_pkg::clamp1(48'($signed(ny_q)));
  assign zz = chs_pkg::clamp1(48'($signed(nz_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q  <= '0;
      ny_q  <= '0;
      nz_q  <= 16'(chs_pkg::ONE);
      thr_q <= 15'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        chs_pkg::REG_NORMAL_X: nx_q  <= cfg_data_i;
        chs_pkg::REG_NORMAL_Y: ny_q  <= cfg_data_i;
        chs_pkg::REG_NORMAL_Z: nz_q  <= cfg_data_i;
        chs_pkg::REG_POLE_THR: thr_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign zsq   = zz * zz;
  assign abs_x = zx[15] ? 16'(-zx) : 16'(zx);
  assign abs_y = zy[15] ? 16'(-zy) : 16'(zy);
  assign trial = root_q | (15'(1) << cnt_q);
  assign sq    = 30'(trial) * 30'(trial);
  assign pole  = (root_q == '0) || (root_q < thr_q);
  assign p_yx  = zz * xy_q;
  assign p_yy  = zz * xx_q;
  assign p_zxy = zx * xy_q;
  assign p_zyx = zy * xx_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    root_d  = root_q;
    n_d     = n_q;
    na_d    = na_q;
    nb_d    = nb_q;
    rema_d  = rema_q;
    remb_d  = remb_q;
    qa_d    = qa_q;
    qb_d    = qb_q;
    xx_d    = xx_q;
    xy_d    = xy_q;
    yx_d    = yx_q;
    yy_d    = yy_q;
    yz_d    = yz_q;
    ra      = {rema_q[14:0], na_q[cnt_q]};
    rb      = {remb_q[14:0], nb_q[cnt_q]};
    mag_a   = '0;
    mag_b   = '0;
    unique case (state_q)
      F_IDLE: ;
      F_LOAD: begin
        n_d     = 29'(32'(chs_pkg::ONE * chs_pkg::ONE) - zsq);
        na_d    = 29'(abs_y) << chs_pkg::VECTOR_FRAC_BITS;
        nb_d    = 29'(abs_x) << chs_pkg::VECTOR_FRAC_BITS;
        root_d  = '0;
        cnt_d   = 5'd14;
        state_d = F_SQRT;
      end
      F_SQRT: begin
        if (sq <= 30'(n_q)) root_d = trial;
        if (cnt_q == '0) begin
          cnt_d   = 5'd28;
          rema_d  = '0;
          remb_d  = '0;
          qa_d    = '0;
          qb_d    = '0;
          state_d = F_DIV;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      F_DIV: begin
        // restoring division of both tangent components by the root of one minus zz squared
        if (ra >= {1'b0, root_q}) begin
          rema_d = ra - {1'b0, root_q};
          qa_d   = {qa_q[27:0], 1'b1};
        end else begin
          rema_d = ra;
          qa_d   = {qa_q[27:0], 1'b0};
        end
        if (rb >= {1'b0, root_q}) begin
          remb_d = rb - {1'b0, root_q};
          qb_d   = {qb_q[27:0], 1'b1};
        end else begin
          remb_d = rb;
          qb_d   = {qb_q[27:0], 1'b0};
        end
        if (cnt_q == '0) begin
          mag_a = (qa_d > 29'(chs_pkg::ONE)) ? 16'(chs_pkg::ONE) : qa_d[15:0];
          mag_b = (qb_d > 29'(chs_pkg::ONE)) ? 16'(chs_pkg::ONE) : qb_d[15:0];
          if (pole) begin
            xx_d = 16'(chs_pkg::ONE);
            xy_d = '0;
          end else begin
            xx_d = zy[15] ? -$signed(mag_a) : $signed(mag_a);
            xy_d = zx[15] ? $signed(mag_b) : -$signed(mag_b);
          end
          state_d = F_CROSS;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      F_CROSS: begin
        yx_d = chs_pkg::clamp1(chs_pkg::rnd_shift(-48'(p_yx), chs_pkg::VECTOR_FRAC_BITS));
        yy_d = chs_pkg::clamp1(chs_pkg::rnd_shift(48'(p_yy), chs_pkg::VECTOR_FRAC_BITS));
        yz_d = chs_pkg::clamp1(chs_pkg::rnd_shift(48'(p_zxy) - 48'(p_zyx),
                                                  chs_pkg::VECTOR_FRAC_BITS));
        state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
    // any register write restarts the build
    if (cfg_valid_i) state_d = F_LOAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      xx_q    <= 16'(chs_pkg::ONE);
      xy_q    <= '0;
      yx_q    <= '0;
      yy_q    <= 16'(chs_pkg::ONE);
      yz_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      xx_q    <= xx_d;
      xy_q    <= xy_d;
      yx_q    <= yx_d;
      yy_q    <= yy_d;
      yz_q    <= yz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    n_q    <= n_d;
    na_q   <= na_d;
    nb_q   <= nb_d;
    rema_q <= rema_d;
    remb_q <= remb_d;
    qa_q   <= qa_d;
    qb_q   <= qb_d;
  end

  assign frame_o.busy = (state_q != F_IDLE);
  assign frame_o.zx   = zx;
  assign frame_o.zy   = zy;
  assign frame_o.zz   = zz;
  assign frame_o.xx   = xx_q;
  assign frame_o.xy   = xy_q;
  assign frame_o.yx   = yx_q;
  assign frame_o.yy   = yy_q;
  assign frame_o.yz   = yz_q;

endmodule

// ----- rtl/chs_angle_pipe.sv -----
// ----------------------------------------------------------------------------
// chs_angle_pipe
// CORDIC rotation pipeline for cos/sin of the azimuth, with two square root
// lanes for the polar cosine and sine riding along the same stages.
// ----------------------------------------------------------------------------
module chs_angle_pipe (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [chs_pkg::SAMPLE_BITS-1:0]  azimuth_i,
  input  logic [chs_pkg::SAMPLE_BITS-1:0]  elevation_i,
  output chs_pkg::angle_t                  angle_o
);

  localparam int N = chs_pkg::CORDIC_STEPS;

  logic                              valid_q [N];
  logic signed [chs_pkg::CW-1:0]     x_q [N];
  logic signed [chs_pkg::CW-1:0]     y_q [N];
  logic signed [chs_pkg::CW-1:0]     z_q [N];
  logic [1:0]                        quad_q [N];
  logic [chs_pkg::SQ_IN_W-1:0]       v_q [N][2];
  logic [chs_pkg::REM_W-1:0]         rem_q [N][2];
  logic [chs_pkg::SQ_STEPS-1:0]      res_q [N][2];

  logic [31:0] turn;
  assign turn = 32'(azimuth_i) << (32 - chs_pkg::SAMPLE_BITS);

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                          valid_in;
    logic signed [chs_pkg::CW-1:0] x_in, y_in, z_in, x_d, y_d, z_d;
    logic [1:0]                    quad_in;
    logic [chs_pkg::SQ_IN_W-1:0]   v_in [2];
    logic [chs_pkg::REM_W-1:0]     rem_in [2];
    logic [chs_pkg::REM_W-1:0]     rem_d [2];
    logic [chs_pkg::SQ_STEPS-1:0]  res_in [2];
    logic [chs_pkg::SQ_STEPS-1:0]  res_d [2];

    if (s == 0) begin : g_first
      assign valid_in  = valid_i;
      assign x_in      = chs_pkg::CW'(chs_pkg::GAIN_Q30);
      assign y_in      = '0;
      assign z_in      = $signed(chs_pkg::CW'(turn[29:0]));
      assign quad_in   = turn[31:30];
      assign v_in[0]   = chs_pkg::SQ_IN_W'(1 << chs_pkg::SAMPLE_BITS)
                         - chs_pkg::SQ_IN_W'(elevation_i);
      assign v_in[1]   = chs_pkg::SQ_IN_W'(elevation_i);
      assign rem_in[0] = '0;
      assign rem_in[1] = '0;
      assign res_in[0] = '0;
      assign res_in[1] = '0;
    end else begin : g_next
      assign valid_in  = valid_q[s-1];
      assign x_in      = x_q[s-1];
      assign y_in      = y_q[s-1];
      assign z_in      = z_q[s-1];
      assign quad_in   = quad_q[s-1];
      assign v_in[0]   = v_q[s-1][0];
      assign v_in[1]   = v_q[s-1][1];
      assign rem_in[0] = rem_q[s-1][0];
      assign rem_in[1] = rem_q[s-1][1];
      assign res_in[0] = res_q[s-1][0];
      assign res_in[1] = res_q[s-1][1];
    end

    always_comb begin
      logic signed [chs_pkg::CW-1:0] xs, ys, at;
      xs = x_in >>> s;
      ys = y_in >>> s;
      at = $signed(chs_pkg::CW'(chs_pkg::atan_turn(5'(s))));
      if (!z_in[chs_pkg::CW-1]) begin
        x_d = x_in - ys;
        y_d = y_in + xs;
        z_d = z_in - at;
      end else begin
        x_d = x_in + ys;
        y_d = y_in - xs;
        z_d = z_in + at;
      end
    end

    // digit-by-digit root, a few result bits per stage
    always_comb begin
      logic [chs_pkg::REM_W-1:0]    rem;
      logic [chs_pkg::REM_W-1:0]    trial;
      logic [chs_pkg::SQ_STEPS-1:0] res;
      logic [chs_pkg::SQ_N_W-1:0]   n;
      for (int l = 0; l < 2; l++) begin
        rem = rem_in[l];
        res = res_in[l];
        n   = chs_pkg::SQ_N_W'(v_in[l]) << chs_pkg::SQ_SHIFT;
        for (int j = 0; j < chs_pkg::SQ_PER_STAGE; j++) begin
          rem   = {rem[chs_pkg::REM_W-3:0],
                   n[chs_pkg::SQ_N_W-1-2*(s*chs_pkg::SQ_PER_STAGE+j) -: 2]};
          trial = {1'b0, res, 2'b01};
          if (rem >= trial) begin
            rem = rem - trial;
            res = {res[chs_pkg::SQ_STEPS-2:0], 1'b1};
          end else begin
            res = {res[chs_pkg::SQ_STEPS-2:0], 1'b0};
          end
        end
        rem_d[l] = rem;
        res_d[l] = res;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]      <= x_d;
        y_q[s]      <= y_d;
        z_q[s]      <= z_d;
        quad_q[s]   <= quad_in;
        v_q[s][0]   <= v_in[0];
        v_q[s][1]   <= v_in[1];
        rem_q[s][0] <= rem_d[0];
        rem_q[s][1] <= rem_d[1];
        res_q[s][0] <= res_d[0];
        res_q[s][1] <= res_d[1];
      end
    end
  end

  assign angle_o.valid   = valid_q[N-1];
  assign angle_o.x       = x_q[N-1];
  assign angle_o.y       = y_q[N-1];
  assign angle_o.quad    = quad_q[N-1];
  assign angle_o.ct_root = res_q[N-1][0];
  assign angle_o.st_root = res_q[N-1][1];

endmodule

// ----- rtl/cosine_hemisphere_sampler_top.sv -----
// ----------------------------------------------------------------------------
// cosine_hemisphere_sampler_top
// Maps pairs of uniform fractions to cosine-weighted directions about a
// configured normal, with the sample density.
// ----------------------------------------------------------------------------
// One request per clock is taken while the output is not stalled and the frame
// builder is idle, and one result per request is returned after one stage per
// CORDIC rotation, which also carries the square root digits, then five stages
// of rounding, products and saturation. The whole pipeline stalls while the
// output register holds a result that is not taken. After any configuration
// write the frame builder runs its load, 15 root steps, 29 division steps
// and the cross product, during which input ready stays low.
module cosine_hemisphere_sampler_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  chs_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output chs_pkg::out_t   out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i
);

  localparam int F  = chs_pkg::VECTOR_FRAC_BITS;
  localparam int CS = chs_pkg::WORK_BITS - chs_pkg::VECTOR_FRAC_BITS;

  chs_pkg::frame_t frm;
  chs_pkg::angle_t ang;
  logic            en;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en && !frm.busy;

  chs_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .frame_o     (frm)
  );

  chs_angle_pipe u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i && in_ready_o),
    .azimuth_i   (in_data_i.rand_azimuth),
    .elevation_i (in_data_i.rand_elevation),
    .angle_o     (ang)
  );

  // stage A: round CORDIC and roots, fold in the quadrant
  logic               a_valid_q;
  logic signed [15:0] a_cphi_q, a_sphi_q, a_ct_q, a_st_q;
  logic signed [15:0] cc, ss, cphi_d, sphi_d;

  assign cc = chs_pkg::clamp1(chs_pkg::rnd_shift(48'(ang.x), CS));
  assign ss = chs_pkg::clamp1(chs_pkg::rnd_shift(48'(ang.y), CS));

  always_comb begin
    case (ang.quad)
      2'd0:    begin cphi_d = cc;  sphi_d = ss;  end
      2'd1:    begin cphi_d = -ss; sphi_d = cc;  end
      2'd2:    begin cphi_d = -cc; sphi_d = -ss; end
      default: begin cphi_d = ss;  sphi_d = -cc; end
    endcase
  end

  // stage B: tangent-plane products and density product
  logic               b_valid_q;
  logic signed [32:0] b_hx_q, b_hy_q, b_hz_q;
  logic [45:0]        b_dens_q;
  logic signed [15:0] b_ct_q, b_st_q;
  logic signed [31:0] p_cx, p_sx, p_cy, p_sy, p_sz;

  assign p_cx = a_cphi_q * frm.xx;
  assign p_sx = a_sphi_q * frm.yx;
  assign p_cy = a_cphi_q * frm.xy;
  assign p_sy = a_sphi_q * frm.yy;
  assign p_sz = a_sphi_q * frm.yz;

  // stage C: round h, finish density
  logic               c_valid_q;
  logic signed [17:0] c_hx_q, c_hy_q, c_hz_q;
  logic [14:0]        c_dens_q;
  logic signed [15:0] c_ct_q, c_st_q;
  logic [45:0]        dens_r;

  assign dens_r = (b_dens_q + (46'(1) << (chs_pkg::DENS_SHIFT - 1))) >> chs_pkg::DENS_SHIFT;

  // stage D: polar sine * h + polar cosine * Z
  logic               d_valid_q;
  logic signed [35:0] d_ox_q, d_oy_q, d_oz_q;
  logic [14:0]        d_dens_q;
  logic signed [33:0] q_sx, q_sy, q_sz;
  logic signed [31:0] q_cx, q_cy, q_cz;

  assign q_sx = c_st_q * c_hx_q;
  assign q_sy = c_st_q * c_hy_q;
  assign q_sz = c_st_q * c_hz_q;
  assign q_cx = c_ct_q * frm.zx;
  assign q_cy = c_ct_q * frm.zy;
  assign q_cz = c_ct_q * frm.zz;

  // stage E: output register
  chs_pkg::out_t out_q;
  logic          e_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= ang.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_cphi_q <= cphi_d;
      a_sphi_q <= sphi_d;
      a_ct_q   <= 16'(chs_pkg::rnd_shift(48'(ang.ct_root), CS));
      a_st_q   <= 16'(chs_pkg::rnd_shift(48'(ang.st_root), CS));

      b_hx_q   <= 33'(p_cx) + 33'(p_sx);
      b_hy_q   <= 33'(p_cy) + 33'(p_sy);
      b_hz_q   <= 33'(p_sz);
      b_dens_q <= 46'(46'(a_ct_q) * 46'(chs_pkg::INV_PI_Q32));
      b_ct_q   <= a_ct_q;
      b_st_q   <= a_st_q;

      c_hx_q   <= 18'(chs_pkg::rnd_shift(48'(b_hx_q), F));
      c_hy_q   <= 18'(chs_pkg::rnd_shift(48'(b_hy_q), F));
      c_hz_q   <= 18'(chs_pkg::rnd_shift(48'(b_hz_q), F));
      c_dens_q <= (dens_r > 46'(chs_pkg::DENS_MAX)) ? 15'(chs_pkg::DENS_MAX) : dens_r[14:0];
      c_ct_q   <= b_ct_q;
      c_st_q   <= b_st_q;

      d_ox_q   <= 36'(q_sx) + 36'(q_cx);
      d_oy_q   <= 36'(q_sy) + 36'(q_cy);
      d_oz_q   <= 36'(q_sz) + 36'(q_cz);
      d_dens_q <= c_dens_q;

      out_q.dir_x   <= chs_pkg::clamp1(chs_pkg::rnd_shift(48'(d_ox_q), F));
      out_q.dir_y   <= chs_pkg::clamp1(chs_pkg::rnd_shift(48'(d_oy_q), F));
      out_q.dir_z   <= chs_pkg::clamp1(chs_pkg::rnd_shift(48'(d_oz_q), F));
      out_q.density <= d_dens_q;
    end
  end

  assign out_valid_o = e_valid_q;
  assign out_data_o  = out_q;

  // a register write always holds off requests in the following cycle
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> !in_ready_o)
    else $error("request accepted while frame is rebuilt");

  a_density_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.density <= 15'd20861))
    else $error("density above its upper bound");

  a_dir_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.dir_x <= 16'sd16384) && (out_data_o.dir_x >= -16'sd16384))
    else $error("dir_x not saturated");

  a_dir_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.dir_z <= 16'sd16384) && (out_data_o.dir_z >= -16'sd16384))
    else $error("dir_z not saturated");

endmodule
